### rtl/core/sfrt_pkg.sv
// ----------------------------------------------------------------------------
// sfrt_pkg
// shared types and constants for the sampled flow rate table
// ----------------------------------------------------------------------------
package sfrt_pkg;

  localparam logic       CMD_SAMPLE  = 1'b0;
  localparam logic       CMD_TICK    = 1'b1;

  localparam logic       KIND_STATUS = 1'b0;
  localparam logic       KIND_RATE   = 1'b1;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_NEW_LINK = 3'd1;
  localparam logic [2:0] ST_NEW_FLOW = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [7:0]  TCP_PROTO  = 8'd6;
  localparam logic [15:0] RESET_RATE = 16'd256;

  typedef struct packed {
    logic        cmd;
    logic [31:0] agent_addr;
    logic [31:0] ingress_port;
    logic [15:0] frame_bytes;
    logic [7:0]  ip_protocol;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } sfrt_in_t;

  typedef struct packed {
    logic        report_kind;
    logic [2:0]  status;
    logic [31:0] flow_source_addr;
    logic [31:0] flow_dest_addr;
    logic [15:0] flow_source_port;
    logic [15:0] flow_dest_port;
    logic [3:0]  active_links;
    logic [63:0] rate_estimate;
    logic        last;
  } sfrt_out_t;

endpackage

### rtl/core/sampled_flow_rate_table_core.sv
// ----------------------------------------------------------------------------
// sampled_flow_rate_table_core
// sampled tcp flow byte accounting with per-interval rate reports
// ----------------------------------------------------------------------------
// One item is handled at a time; in_ready is high only when the sequencer is
// idle. A sample walks the flow table, reading then comparing each used flow,
// then the flow's links in the same way, reading then comparing each link, and
// then loads the result; a miss passes through a further state that claims a
// new flow or a new link. A tick visits every used flow: it reads the flow's
// entry, then for each link reads it, scales it through the shared multiplier
// and accumulates it, runs the bit-serial divider when any link rate is
// nonzero, and presents the report, waiting while the previous report still
// sits in the output register. Flows and links are claimed in slot order and
// never freed, so a flow fill count and a per-flow link count stand in for
// valid bits and no clearing pass is needed after reset. The flow table and
// the link table each have one write port and one read port with registered
// read data. The sampling rate is written only while the sequencer is idle.
// The output word sits in its own register, so a report waits there while the
// sequencer moves on to the next flow.
module sampled_flow_rate_table_core #(
  parameter int FLOW_SLOTS = 64,
  parameter int LINK_SLOTS = 8,
  parameter int COUNT_BITS = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfrt_pkg::sfrt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sfrt_pkg::sfrt_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import sfrt_pkg::*;

  // table geometry
  localparam int FW  = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int FCW = $clog2(FLOW_SLOTS + 1);
  localparam int LW  = (LINK_SLOTS > 1) ? $clog2(LINK_SLOTS) : 1;
  localparam int LCW = $clog2(LINK_SLOTS + 1);
  localparam int AW  = FW + LW;
  // scaled rate: bytes * 8 * sampling rate, wide enough to see overflow
  localparam int PW  = COUNT_BITS + 19;
  localparam int PWX = (PW > 65) ? PW : 65;

  typedef struct packed {
    logic [31:0]    src;
    logic [31:0]    dst;
    logic [15:0]    sport;
    logic [15:0]    dport;
    logic [LCW-1:0] nlinks;
  } flow_ent_t;

  typedef struct packed {
    logic [31:0]           agent;
    logic [31:0]           ifx;
    logic [COUNT_BITS-1:0] bytes;
  } link_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE, S_FRD, S_FCMP, S_FMISS, S_LRD, S_LCMP, S_LMISS,
    T_FRD, T_FCHK, T_LRD, T_MUL, T_ACC, T_DIVST, T_DIVW, ST_EMIT
  } state_t;

  state_t state_r;

  // memories
  flow_ent_t flow_mem [2**FW];
  link_ent_t link_mem [2**AW];
  flow_ent_t flow_rd_r;
  link_ent_t link_rd_r;

  logic          flow_we;
  logic [FW-1:0] flow_wa;
  flow_ent_t     flow_wd;
  logic          link_we;
  logic [AW-1:0] link_wa;
  link_ent_t     link_wd;

  // sequencer state
  sfrt_in_t       in_r;
  logic [15:0]    rate_r;
  logic [FCW-1:0] flow_count_r;
  logic [FW-1:0]  f_r;
  logic [LW-1:0]  l_r;
  logic [LCW-1:0] nlinks_r;
  logic [31:0]    ksrc_r;
  logic [31:0]    kdst_r;
  logic [15:0]    ksp_r;
  logic [15:0]    kdp_r;
  logic           kind_r;
  logic [2:0]     status_r;
  logic [63:0]    sum_r;
  logic [LCW-1:0] act_r;
  logic [63:0]    rprod_r;
  logic [63:0]    est_r;
  sfrt_out_t      out_r;
  logic           out_valid_r;

  // comparisons and arithmetic
  logic                  key_hit;
  logic                  link_hit;
  logic                  flow_last;
  logic                  link_last;
  logic [COUNT_BITS:0]   add_sum;
  logic [COUNT_BITS-1:0] add_sat;
  logic [PWX-1:0]        prod;
  logic [63:0]           rate_sat;
  logic [64:0]           acc_sum;
  logic                  out_free;
  logic                  out_load;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [63:0]           div_q;

  assign key_hit   = (flow_rd_r.src == in_r.source_addr) &&
                     (flow_rd_r.dst == in_r.dest_addr) &&
                     (flow_rd_r.sport == in_r.source_port) &&
                     (flow_rd_r.dport == in_r.dest_port);
  assign link_hit  = (link_rd_r.agent == in_r.agent_addr) &&
                     (link_rd_r.ifx == in_r.ingress_port);
  assign flow_last = (FCW'(f_r) + FCW'(1)) == flow_count_r;
  assign link_last = (LCW'(l_r) + LCW'(1)) == nlinks_r;

  // saturating byte count update
  assign add_sum = {1'b0, link_rd_r.bytes} + (COUNT_BITS + 1)'(in_r.frame_bytes);
  assign add_sat = add_sum[COUNT_BITS] ? '1 : add_sum[COUNT_BITS-1:0];

  // shared multiplier: bytes * 8 * sampling rate, saturated at 64 bits
  assign prod     = PWX'({link_rd_r.bytes, 3'b000}) * PWX'(rate_r);
  assign rate_sat = (|prod[PWX-1:64]) ? '1 : prod[63:0];

  assign acc_sum  = {1'b0, sum_r} + {1'b0, rprod_r};
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == ST_EMIT) && out_free;

  // memory port control
  always_comb begin
    flow_we = 1'b0;
    flow_wa = f_r;
    flow_wd = '{src: in_r.source_addr, dst: in_r.dest_addr,
                sport: in_r.source_port, dport: in_r.dest_port,
                nlinks: nlinks_r + LCW'(1)};
    link_we = 1'b0;
    link_wa = {f_r, l_r};
    link_wd = '{agent: in_r.agent_addr, ifx: in_r.ingress_port,
                bytes: COUNT_BITS'(in_r.frame_bytes)};
    unique case (state_r)
      S_FMISS: begin
        if (flow_count_r != FCW'(FLOW_SLOTS)) begin
          // new flow: first link with a zero count
          flow_we        = 1'b1;
          flow_wa        = flow_count_r[FW-1:0];
          flow_wd.nlinks = LCW'(1);
          link_we        = 1'b1;
          link_wa        = {flow_count_r[FW-1:0], LW'(0)};
          link_wd.bytes  = '0;
        end
      end
      S_LCMP: begin
        if (link_hit) begin
          link_we       = 1'b1;
          link_wd.bytes = add_sat;
        end
      end
      S_LMISS: begin
        if (nlinks_r != LCW'(LINK_SLOTS)) begin
          flow_we = 1'b1;
          link_we = 1'b1;
          link_wa = {f_r, nlinks_r[LW-1:0]};
        end
      end
      T_MUL: begin
        // counter is read out and cleared for the next interval
        link_we       = 1'b1;
        link_wd.agent = link_rd_r.agent;
        link_wd.ifx   = link_rd_r.ifx;
        link_wd.bytes = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (flow_we) flow_mem[flow_wa] <= flow_wd;
    flow_rd_r <= flow_mem[f_r];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_r <= link_mem[{f_r, l_r}];
  end

  assign div_start = (state_r == T_DIVST) && (act_r != '0);

  sfrt_div #(
    .DW(LCW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (act_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // configuration register, written only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RESET_RATE;
    end else if (cfg_valid && cfg_ready) begin
      rate_r <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      flow_count_r <= '0;
      out_valid_r  <= 1'b0;
      f_r          <= '0;
      l_r          <= '0;
    end else begin
      if (out_ready && !out_load) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            in_r     <= in_data;
            ksrc_r   <= in_data.source_addr;
            kdst_r   <= in_data.dest_addr;
            ksp_r    <= in_data.source_port;
            kdp_r    <= in_data.dest_port;
            kind_r   <= (in_data.cmd == CMD_TICK) ? KIND_RATE : KIND_STATUS;
            act_r    <= '0;
            est_r    <= '0;
            f_r      <= '0;
            l_r      <= '0;
            if (in_data.cmd == CMD_TICK) begin
              status_r <= ST_UPDATED;
              // an empty table gives no reports
              if (flow_count_r != '0) state_r <= T_FRD;
            end else if (in_data.ip_protocol != TCP_PROTO) begin
              status_r <= ST_IGNORED;
              state_r  <= ST_EMIT;
            end else if (flow_count_r == '0) begin
              state_r <= S_FMISS;
            end else begin
              state_r <= S_FRD;
            end
          end
        end
        S_FRD: state_r <= S_FCMP;
        S_FCMP: begin
          if (key_hit) begin
            nlinks_r <= flow_rd_r.nlinks;
            l_r      <= '0;
            state_r  <= S_LRD;
          end else if (flow_last) begin
            state_r <= S_FMISS;
          end else begin
            f_r     <= f_r + FW'(1);
            state_r <= S_FRD;
          end
        end
        S_FMISS: begin
          if (flow_count_r == FCW'(FLOW_SLOTS)) begin
            status_r <= ST_FULL;
          end else begin
            status_r     <= ST_NEW_FLOW;
            flow_count_r <= flow_count_r + FCW'(1);
          end
          state_r <= ST_EMIT;
        end
        S_LRD: state_r <= S_LCMP;
        S_LCMP: begin
          if (link_hit) begin
            status_r <= ST_UPDATED;
            state_r  <= ST_EMIT;
          end else if (link_last) begin
            state_r <= S_LMISS;
          end else begin
            l_r     <= l_r + LW'(1);
            state_r <= S_LRD;
          end
        end
        S_LMISS: begin
          status_r <= (nlinks_r == LCW'(LINK_SLOTS)) ? ST_FULL : ST_NEW_LINK;
          state_r  <= ST_EMIT;
        end
        T_FRD: state_r <= T_FCHK;
        T_FCHK: begin
          ksrc_r   <= flow_rd_r.src;
          kdst_r   <= flow_rd_r.dst;
          ksp_r    <= flow_rd_r.sport;
          kdp_r    <= flow_rd_r.dport;
          nlinks_r <= flow_rd_r.nlinks;
          sum_r    <= '0;
          act_r    <= '0;
          l_r      <= '0;
          state_r  <= T_LRD;
        end
        T_LRD: state_r <= T_MUL;
        T_MUL: begin
          rprod_r <= rate_sat;
          state_r <= T_ACC;
        end
        T_ACC: begin
          sum_r <= acc_sum[64] ? '1 : acc_sum[63:0];
          if (rprod_r != '0) act_r <= act_r + LCW'(1);
          if (link_last) begin
            state_r <= T_DIVST;
          end else begin
            l_r     <= l_r + LW'(1);
            state_r <= T_LRD;
          end
        end
        T_DIVST: begin
          // no active link: estimate is zero, divider not used
          est_r   <= '0;
          state_r <= (act_r != '0) ? T_DIVW : ST_EMIT;
        end
        T_DIVW: begin
          if (div_done) begin
            est_r   <= div_q;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_r <= '{report_kind: kind_r, status: status_r,
                       flow_source_addr: ksrc_r, flow_dest_addr: kdst_r,
                       flow_source_port: ksp_r, flow_dest_port: kdp_r,
                       active_links: 4'(act_r), rate_estimate: est_r,
                       last: (kind_r == KIND_STATUS) || flow_last};
            if ((kind_r == KIND_RATE) && !flow_last) begin
              f_r     <= f_r + FW'(1);
              state_r <= T_FRD;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    flow_count_r <= FCW'(FLOW_SLOTS))
    else $error("flow count beyond table size");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == T_DIVW))
    else $error("divider busy outside the divide wait");

  a_sample_multi: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd == CMD_SAMPLE) |=> !in_ready)
    else $error("sample finished in a single cycle");

endmodule

### rtl/core/sfrt_div.sv
// ----------------------------------------------------------------------------
// sfrt_div
// restoring divider, 64 bit dividend by a narrow divisor, one bit a cycle
// ----------------------------------------------------------------------------
module sfrt_div #(
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [63:0]   quotient
);

  logic [63:0]   q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, q_r[63]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        // remainder stays below the divisor, so it fits DW bits
        rem_r <= fits ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
        q_r   <= {q_r[62:0], fits};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

### tb/sv/tb_sampled_flow_rate_table_core.sv
// ----------------------------------------------------------------------------
// tb_sampled_flow_rate_table_core
// self-checking bench: random and directed samples and ticks against a model
// ----------------------------------------------------------------------------
module tb_sampled_flow_rate_table_core;
  import sfrt_pkg::*;

  localparam int FLOWS = 64;
  localparam int LINKS = 8;
  localparam int CBITS = 48;
  localparam int IN_BITS = $bits(sfrt_in_t);
  localparam logic [47:0] COUNT_TOP = {CBITS{1'b1}};
  localparam logic [63:0] RATE_TOP = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sfrt_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sfrt_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  sampled_flow_rate_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the flow and link tables
  logic [15:0] shadow_rate;
  logic        fl_used [FLOWS];
  logic [31:0] fl_src [FLOWS];
  logic [31:0] fl_dst [FLOWS];
  logic [15:0] fl_sp [FLOWS];
  logic [15:0] fl_dp [FLOWS];
  logic        ln_used [FLOWS*LINKS];
  logic [31:0] ln_agent [FLOWS*LINKS];
  logic [31:0] ln_ifx [FLOWS*LINKS];
  logic [47:0] ln_bytes [FLOWS*LINKS];

  sfrt_in_t  pending_words[$];
  sfrt_out_t expected_reports[$];
  int n_fail = 0;
  int n_checked = 0;
  int n_rate_reports = 0;
  int send_idle_pct = 9;
  int recv_idle_pct = 57;
  int hold_off = 0;
  logic send_pause = 1'b0;

  function automatic logic [63:0] bits_scaled(logic [47:0] bytes);
    logic [127:0] prod;
    prod = {77'd0, bytes, 3'd0} * {112'd0, shadow_rate};
    return (prod[127:64] != 0) ? RATE_TOP : prod[63:0];
  endfunction

  // works out the words that one accepted input word causes
  task automatic account_word(sfrt_in_t w);
    sfrt_out_t r;
    int hit, free_f, free_l, base;
    logic [2:0] st;
    logic [63:0] sum, lr;
    logic [3:0] act;
    logic [48:0] grown;
    if (w.cmd == CMD_TICK) begin
      hit = -1;
      for (int f = 0; f < FLOWS; f++) begin
        if (!fl_used[f]) continue;
        sum = '0; act = '0;
        for (int l = 0; l < LINKS; l++) begin
          if (!ln_used[f*LINKS+l]) continue;
          lr = bits_scaled(ln_bytes[f*LINKS+l]);
          ln_bytes[f*LINKS+l] = '0;
          sum = (sum > RATE_TOP - lr) ? RATE_TOP : sum + lr;
          if (lr != 0) act++;
        end
        r = '0;
        r.report_kind = KIND_RATE;
        r.status = ST_UPDATED;
        r.flow_source_addr = fl_src[f];
        r.flow_dest_addr = fl_dst[f];
        r.flow_source_port = fl_sp[f];
        r.flow_dest_port = fl_dp[f];
        r.active_links = act;
        r.rate_estimate = (act != 0) ? sum / act : 64'd0;
        expected_reports.push_back(r);
        hit = f;
      end
      // last flag on the final report of the tick
      if (hit >= 0) expected_reports[$].last = 1'b1;
      return;
    end
    if (w.ip_protocol != TCP_PROTO) begin
      st = ST_IGNORED;
    end else begin
      hit = -1; free_f = -1;
      for (int f = 0; f < FLOWS; f++) begin
        if (fl_used[f]) begin
          if (hit < 0 && fl_src[f] == w.source_addr && fl_dst[f] == w.dest_addr &&
              fl_sp[f] == w.source_port && fl_dp[f] == w.dest_port) hit = f;
        end else if (free_f < 0) free_f = f;
      end
      if (hit < 0) begin
        if (free_f < 0) st = ST_FULL;
        else begin
          for (int l = 0; l < LINKS; l++) ln_used[free_f*LINKS+l] = 1'b0;
          fl_used[free_f] = 1'b1;
          fl_src[free_f] = w.source_addr;
          fl_dst[free_f] = w.dest_addr;
          fl_sp[free_f] = w.source_port;
          fl_dp[free_f] = w.dest_port;
          ln_used[free_f*LINKS] = 1'b1;
          ln_agent[free_f*LINKS] = w.agent_addr;
          ln_ifx[free_f*LINKS] = w.ingress_port;
          ln_bytes[free_f*LINKS] = '0;
          st = ST_NEW_FLOW;
        end
      end else begin
        base = hit * LINKS; free_l = -1; st = ST_FULL;
        for (int l = 0; l < LINKS; l++) begin
          if (ln_used[base+l]) begin
            if (ln_agent[base+l] == w.agent_addr && ln_ifx[base+l] == w.ingress_port) begin
              grown = {1'b0, ln_bytes[base+l]} + 49'(w.frame_bytes);
              ln_bytes[base+l] = grown[48] ? COUNT_TOP : grown[47:0];
              st = ST_UPDATED;
              break;
            end
          end else if (free_l < 0) free_l = l;
        end
        if (st != ST_UPDATED && free_l >= 0) begin
          ln_used[base+free_l] = 1'b1;
          ln_agent[base+free_l] = w.agent_addr;
          ln_ifx[base+free_l] = w.ingress_port;
          ln_bytes[base+free_l] = 48'(w.frame_bytes);
          st = ST_NEW_LINK;
        end
      end
    end
    r = '0;
    r.report_kind = KIND_STATUS;
    r.status = st;
    r.flow_source_addr = w.source_addr;
    r.flow_dest_addr = w.dest_addr;
    r.flow_source_port = w.source_port;
    r.flow_dest_port = w.dest_port;
    r.last = 1'b1;
    expected_reports.push_back(r);
  endtask

  // driver: next word goes up once the previous one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) account_word(in_data);
      if (pending_words.size() != 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    sfrt_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected output word %h", out_data);
        n_fail++;
      end else begin
        e = expected_reports.pop_front();
        n_checked++;
        if (e.report_kind == KIND_RATE) n_rate_reports++;
        if (out_data.report_kind !== e.report_kind) begin
          $error("report_kind exp %0d got %0d", e.report_kind, out_data.report_kind); n_fail++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status); n_fail++;
        end
        if (out_data.flow_source_addr !== e.flow_source_addr) begin
          $error("flow_source_addr exp %h got %h", e.flow_source_addr,
                 out_data.flow_source_addr); n_fail++;
        end
        if (out_data.flow_dest_addr !== e.flow_dest_addr) begin
          $error("flow_dest_addr exp %h got %h", e.flow_dest_addr,
                 out_data.flow_dest_addr); n_fail++;
        end
        if (out_data.flow_source_port !== e.flow_source_port) begin
          $error("flow_source_port exp %h got %h", e.flow_source_port,
                 out_data.flow_source_port); n_fail++;
        end
        if (out_data.flow_dest_port !== e.flow_dest_port) begin
          $error("flow_dest_port exp %h got %h", e.flow_dest_port,
                 out_data.flow_dest_port); n_fail++;
        end
        if (out_data.active_links !== e.active_links) begin
          $error("active_links exp %0d got %0d", e.active_links, out_data.active_links);
          n_fail++;
        end
        if (out_data.rate_estimate !== e.rate_estimate) begin
          $error("rate_estimate exp %0d got %0d", e.rate_estimate,
                 out_data.rate_estimate); n_fail++;
        end
        if (out_data.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_data.last); n_fail++;
        end
      end
    end
  end

  function automatic sfrt_in_t sample_word(logic [31:0] s, logic [31:0] d,
                                           logic [15:0] sp, logic [15:0] dp,
                                           logic [31:0] ag, logic [31:0] ifx,
                                           logic [15:0] len);
    sfrt_in_t w;
    w.cmd = CMD_SAMPLE; w.agent_addr = ag; w.ingress_port = ifx;
    w.frame_bytes = len; w.ip_protocol = TCP_PROTO;
    w.source_addr = s; w.dest_addr = d; w.source_port = sp; w.dest_port = dp;
    return w;
  endfunction

  function automatic sfrt_in_t tick_word();
    sfrt_in_t w;
    w = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom});
    w.cmd = CMD_TICK;
    return w;
  endfunction

  // small key pools so that flows and links repeat
  function automatic sfrt_in_t random_word(int n_keys);
    sfrt_in_t w;
    int k, a;
    k = $urandom_range(n_keys - 1);
    a = $urandom_range(9);
    w = sample_word(32'h0a00_0000 ^ (k * 32'h9e37_79b9), 32'hc0a8_0001 + k,
                    16'(k * 977), 16'hffff - 16'(k),
                    32'hac10_0000 + a, (a[0]) ? 32'hffff_ffff : 32'(a),
                    16'($urandom));
    if ($urandom_range(9) == 0) w.ip_protocol = 8'($urandom);
    if ($urandom_range(19) == 0) w = IN_BITS'({$urandom, $urandom, $urandom, $urandom,
                                               $urandom, $urandom, $urandom});
    if ($urandom_range(11) == 0) w = tick_word();
    if (w.cmd == CMD_SAMPLE && $urandom_range(7) == 0) w.frame_bytes = 16'hffff;
    return w;
  endfunction

  task automatic drain(int slack);
    int guard;
    guard = 0;
    while ((pending_words.size() != 0 || in_valid || expected_reports.size() != 0) &&
           guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (slack) @(posedge clk);
  endtask

  task automatic write_rate(logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_rate = v;
  endtask

  initial begin
    sfrt_in_t w;
    shadow_rate = RESET_RATE;
    for (int f = 0; f < FLOWS; f++) fl_used[f] = 1'b0;
    for (int i = 0; i < FLOWS*LINKS; i++) ln_used[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, non-tcp, new flow, new link, update
    pending_words.push_back(tick_word());
    w = sample_word('0, '0, '0, '0, '0, '0, '0);
    w.ip_protocol = 8'hff;
    pending_words.push_back(w);
    w.ip_protocol = 8'h00;
    pending_words.push_back(w);
    pending_words.push_back(sample_word('1, '1, '1, '1, '1, '1, '1));
    pending_words.push_back(sample_word('1, '1, '1, '1, '1, '1, '1));
    pending_words.push_back(sample_word('1, '1, '1, '1, 32'h1, 32'h2, 16'hffff));
    pending_words.push_back(sample_word('0, '0, '0, '0, '0, '0, '0));
    pending_words.push_back(tick_word());
    // flow left with only the zero-count link: no active link
    pending_words.push_back(tick_word());
    // fill every link of one flow, then one more is dropped
    for (int l = 0; l < LINKS + 1; l++)
      pending_words.push_back(sample_word(32'h55, 32'haa, 16'h5, 16'ha, 32'h77,
                                          32'(l), 16'd1000));
    pending_words.push_back(tick_word());
    drain(40);

    // largest rate
    write_rate(16'hffff);
    for (int l = 0; l < LINKS; l++)
      pending_words.push_back(sample_word(32'h55, 32'haa, 16'h5, 16'ha, 32'h77,
                                          32'(l), 16'hffff));
    pending_words.push_back(tick_word());
    drain(40);

    // zero rate is out of range but still taken
    write_rate(16'd0);
    pending_words.push_back(sample_word(32'h55, 32'haa, 16'h5, 16'ha, 32'h77, 32'd3, 16'd9));
    pending_words.push_back(tick_word());
    drain(40);

    // random, phase one
    write_rate(16'd1);
    for (int i = 0; i < 45; i++) pending_words.push_back(random_word(12));
    drain(40);

    // long receiver hold-off while the sender keeps offering
    write_rate(16'd512);
    hold_off = 3000;
    for (int i = 0; i < 20; i++) pending_words.push_back(random_word(12));
    drain(40);

    // other way round
    send_idle_pct = 57;
    recv_idle_pct = 9;
    write_rate(16'($urandom_range(65535, 1)));
    for (int i = 0; i < 55; i++) pending_words.push_back(random_word(40));
    // sender pauses until every expected word is back
    send_pause = 1'b1;
    while (in_valid || expected_reports.size() != 0) @(posedge clk);
    send_pause = 1'b0;
    drain(40);

    // no idling; enough keys to fill the flow table
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_rate(16'd256);
    for (int i = 0; i < 70; i++) pending_words.push_back(random_word(70));
    pending_words.push_back(tick_word());
    drain(200);

    $display("covered %0d checked words, %0d of them flow rate reports",
             n_checked, n_rate_reports);
    if (n_fail == 0 && expected_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
rtl/core/sfrt_pkg.sv
rtl/core/sfrt_div.sv
rtl/core/sampled_flow_rate_table_core.sv
tb/sv/tb_sampled_flow_rate_table_core.sv
